/* design/tltw_pkg.sv */
package tltw_pkg;

    // ring geometry, ring size must be a power of two
    localparam int SLOTS    = 512;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int FP_W     = SLOT_W + 1;
    localparam int SF_AW    = SLOT_W + 1;
    localparam int SF_DEPTH = 2 * SLOTS;

    // timer pool
    localparam int TIMERS   = 64;
    localparam int TID_W    = $clog2(TIMERS);
    localparam int LINK_W   = 7;
    localparam logic [LINK_W-1:0] NO_TIMER = 7'd127;

    // field widths
    localparam int USER_W   = 28;
    localparam int KID_W    = 4;
    localparam int IV_W     = 18;
    localparam int HANDLE_W = 6;
    localparam int SLOW_W   = IV_W - SLOT_W + 1;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_STOP  = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        KIND_STARTED    = 3'd0,
        KIND_STOPPED    = 3'd1,
        KIND_EXPIRED    = 3'd2,
        KIND_TICK_EMPTY = 3'd3,
        KIND_POOL_FULL  = 3'd4,
        KIND_BAD_HANDLE = 3'd5,
        KIND_BAD_IV     = 3'd6
    } t_kind;

    typedef struct packed {
        logic [1:0]          func;
        logic [USER_W-1:0]   user_index;
        logic [KID_W-1:0]    timer_kind;
        logic [IV_W-1:0]     interval;
        logic [HANDLE_W-1:0] handle;
    } t_req;

    typedef struct packed {
        logic [2:0]          kind;
        logic [HANDLE_W-1:0] slot_handle;
        logic [USER_W-1:0]   expired_user;
        logic [KID_W-1:0]    expired_kind;
        logic                last;
    } t_res;

    typedef struct packed {
        logic [SLOT_W-1:0] fast;
        logic [KID_W-1:0]  kid;
        logic [USER_W-1:0] user;
    } t_pay;

    typedef enum logic [3:0] {
        UOP_NONE,
        UOP_CLEAR,
        UOP_CAPTURE,
        UOP_ALLOC,
        UOP_LH_WR,
        UOP_LH_PREV,
        UOP_STOP_RD,
        UOP_STOP_UNL,
        UOP_TICK_CHK,
        UOP_CS_RD,
        UOP_CS_HEAD,
        UOP_CS_GOT,
        UOP_EX_RD,
        UOP_EX_HEAD,
        UOP_EX_OUT
    } t_uop;

    typedef struct packed {
        t_uop  uop;
        logic  emit;
        t_kind kind;
        logic  last;
        logic  finish;
    } t_cmd;

    typedef struct packed {
        logic h_ok;
        logic bad_iv;
        logic full;
        logic wrap;
        logic sf_none;
        logic next_none;
        logic nx_none;
        logic clr_done;
    } t_stat;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_LH_WR,
        ST_LH_PREV,
        ST_STOP_CHK,
        ST_STOP_UNL,
        ST_TICK,
        ST_CS_RD,
        ST_CS_HEAD,
        ST_CS_GOT,
        ST_EX_RD,
        ST_EX_HEAD,
        ST_EX_OUT
    } t_state;

    function automatic logic is_none(input logic [LINK_W-1:0] l);
        return l >= LINK_W'(TIMERS);
    endfunction

endpackage

/* design/tltw_ctrl.sv */
module tltw_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic [1:0]           i_func,
    input  tltw_pkg::t_stat      i_stat,
    output tltw_pkg::t_cmd       o_cmd,
    output logic                 busy
);

    tltw_pkg::t_state r_state, n_state;
    logic r_casc, n_casc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tltw_pkg::ST_CLEAR;
            r_casc  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_casc  <= n_casc;
        end
    end

    assign busy = (r_state != tltw_pkg::ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        n_casc  = r_casc;
        case (r_state)
            tltw_pkg::ST_CLEAR: begin
                if (i_stat.clr_done) n_state = tltw_pkg::ST_IDLE;
            end
            tltw_pkg::ST_IDLE: begin
                if (start) begin
                    case (i_func)
                        tltw_pkg::FUNC_START: n_state = tltw_pkg::ST_START;
                        tltw_pkg::FUNC_STOP:  n_state = tltw_pkg::ST_STOP_CHK;
                        tltw_pkg::FUNC_TICK:  n_state = tltw_pkg::ST_TICK;
                        default:              n_state = tltw_pkg::ST_IDLE;
                    endcase
                end
            end
            tltw_pkg::ST_START: begin
                if (i_stat.bad_iv || i_stat.full) begin
                    n_state = tltw_pkg::ST_IDLE;
                end else begin
                    n_state = tltw_pkg::ST_LH_WR;
                    n_casc  = 1'b0;
                end
            end
            tltw_pkg::ST_LH_WR: n_state = tltw_pkg::ST_LH_PREV;
            tltw_pkg::ST_LH_PREV: begin
                if (!r_casc)              n_state = tltw_pkg::ST_IDLE;
                else if (i_stat.nx_none)  n_state = tltw_pkg::ST_EX_RD;
                else                      n_state = tltw_pkg::ST_CS_GOT;
            end
            tltw_pkg::ST_STOP_CHK: begin
                n_state = i_stat.h_ok ? tltw_pkg::ST_STOP_UNL : tltw_pkg::ST_IDLE;
            end
            tltw_pkg::ST_STOP_UNL: n_state = tltw_pkg::ST_IDLE;
            tltw_pkg::ST_TICK: begin
                n_state = i_stat.wrap ? tltw_pkg::ST_CS_RD : tltw_pkg::ST_EX_RD;
            end
            tltw_pkg::ST_CS_RD: n_state = tltw_pkg::ST_CS_HEAD;
            tltw_pkg::ST_CS_HEAD: begin
                n_state = i_stat.sf_none ? tltw_pkg::ST_EX_RD : tltw_pkg::ST_CS_GOT;
            end
            tltw_pkg::ST_CS_GOT: begin
                n_state = tltw_pkg::ST_LH_WR;
                n_casc  = 1'b1;
            end
            tltw_pkg::ST_EX_RD: n_state = tltw_pkg::ST_EX_HEAD;
            tltw_pkg::ST_EX_HEAD: begin
                n_state = i_stat.sf_none ? tltw_pkg::ST_IDLE : tltw_pkg::ST_EX_OUT;
            end
            tltw_pkg::ST_EX_OUT: begin
                if (i_stat.next_none) n_state = tltw_pkg::ST_IDLE;
            end
            default: n_state = tltw_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd        = '0;
        o_cmd.uop    = tltw_pkg::UOP_NONE;
        o_cmd.kind   = tltw_pkg::KIND_STARTED;
        case (r_state)
            tltw_pkg::ST_CLEAR: o_cmd.uop = tltw_pkg::UOP_CLEAR;
            tltw_pkg::ST_IDLE: begin
                if (start) o_cmd.uop = tltw_pkg::UOP_CAPTURE;
            end
            tltw_pkg::ST_START: begin
                if (i_stat.bad_iv) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = tltw_pkg::KIND_BAD_IV;
                    o_cmd.last = 1'b1;
                end else if (i_stat.full) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = tltw_pkg::KIND_POOL_FULL;
                    o_cmd.last = 1'b1;
                end else begin
                    o_cmd.uop = tltw_pkg::UOP_ALLOC;
                end
            end
            tltw_pkg::ST_LH_WR: o_cmd.uop = tltw_pkg::UOP_LH_WR;
            tltw_pkg::ST_LH_PREV: begin
                o_cmd.uop = tltw_pkg::UOP_LH_PREV;
                if (!r_casc) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = tltw_pkg::KIND_STARTED;
                    o_cmd.last = 1'b1;
                end
            end
            tltw_pkg::ST_STOP_CHK: begin
                if (i_stat.h_ok) begin
                    o_cmd.uop = tltw_pkg::UOP_STOP_RD;
                end else begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = tltw_pkg::KIND_BAD_HANDLE;
                    o_cmd.last = 1'b1;
                end
            end
            tltw_pkg::ST_STOP_UNL: begin
                o_cmd.uop  = tltw_pkg::UOP_STOP_UNL;
                o_cmd.emit = 1'b1;
                o_cmd.kind = tltw_pkg::KIND_STOPPED;
                o_cmd.last = 1'b1;
            end
            tltw_pkg::ST_TICK:    o_cmd.uop = tltw_pkg::UOP_TICK_CHK;
            tltw_pkg::ST_CS_RD:   o_cmd.uop = tltw_pkg::UOP_CS_RD;
            tltw_pkg::ST_CS_HEAD: o_cmd.uop = tltw_pkg::UOP_CS_HEAD;
            tltw_pkg::ST_CS_GOT:  o_cmd.uop = tltw_pkg::UOP_CS_GOT;
            tltw_pkg::ST_EX_RD:   o_cmd.uop = tltw_pkg::UOP_EX_RD;
            tltw_pkg::ST_EX_HEAD: begin
                o_cmd.uop = tltw_pkg::UOP_EX_HEAD;
                if (i_stat.sf_none) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.kind   = tltw_pkg::KIND_TICK_EMPTY;
                    o_cmd.last   = 1'b1;
                    o_cmd.finish = 1'b1;
                end
            end
            tltw_pkg::ST_EX_OUT: begin
                o_cmd.uop    = tltw_pkg::UOP_EX_OUT;
                o_cmd.emit   = 1'b1;
                o_cmd.kind   = tltw_pkg::KIND_EXPIRED;
                o_cmd.last   = i_stat.next_none;
                o_cmd.finish = i_stat.next_none;
            end
            default: o_cmd.uop = tltw_pkg::UOP_NONE;
        endcase
    end

endmodule

/* design/tltw_dp.sv */
module tltw_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tltw_pkg::t_req   i_req,
    input  tltw_pkg::t_cmd   i_cmd,
    output tltw_pkg::t_stat  o_stat,
    output logic             o_strobe,
    output tltw_pkg::t_res   o_res
);

    localparam int SLOT_W = tltw_pkg::SLOT_W;
    localparam int FP_W   = tltw_pkg::FP_W;
    localparam int SF_AW  = tltw_pkg::SF_AW;
    localparam int TID_W  = tltw_pkg::TID_W;
    localparam int LINK_W = tltw_pkg::LINK_W;
    localparam int SLOW_W = tltw_pkg::SLOW_W;
    localparam int TIMERS = tltw_pkg::TIMERS;

    // state registers
    tltw_pkg::t_req     r_req;
    logic [FP_W-1:0]    r_fp;
    logic [SLOT_W-1:0]  r_sp;
    logic [31:0]        r_tick;
    logic [TIMERS-1:0]  r_tbusy;
    logic [SF_AW-1:0]   r_clr;
    logic [LINK_W-1:0]  r_t, r_n, r_nx;
    logic [SF_AW-1:0]   r_s;
    tltw_pkg::t_res     r_res;
    logic               r_strobe;

    // memories
    logic [LINK_W-1:0]  m_sf [tltw_pkg::SF_DEPTH];
    logic [LINK_W-1:0]  m_next [TIMERS];
    logic [LINK_W-1:0]  m_prev [TIMERS];
    tltw_pkg::t_pay     m_pay [TIMERS];
    logic [SF_AW-1:0]   m_tslot [TIMERS];
    logic [LINK_W-1:0]  r_sf_rd, r_next_rd, r_prev_rd;
    tltw_pkg::t_pay     r_pay_rd;
    logic [SF_AW-1:0]   r_tslot_rd;

    // port controls
    logic               sf_we;
    logic [SF_AW-1:0]   sf_wa, sf_ra;
    logic [LINK_W-1:0]  sf_wd;
    logic               nx_we, pv_we, pay_we, ts_we;
    logic [TID_W-1:0]   nx_wa, pv_wa, lk_ra, h_idx;
    logic [LINK_W-1:0]  nx_wd, pv_wd;

    // start arithmetic
    logic [FP_W-1:0]    fsum;
    logic               carry;
    logic [SLOW_W-1:0]  slow;
    logic [31:0]        ssum;
    logic [SF_AW-1:0]   saddr;
    tltw_pkg::t_pay     pay_wd;

    logic               free_ok;
    logic [TID_W-1:0]   free_idx;

    assign h_idx = r_req.handle[TID_W-1:0];

    always_comb begin
        fsum  = {1'b0, r_req.interval[SLOT_W-1:0]} + r_fp;
        carry = (fsum >= FP_W'(tltw_pkg::SLOTS));
        slow  = SLOW_W'(r_req.interval >> SLOT_W) + SLOW_W'(carry);
        ssum  = 32'(slow) + 32'(r_sp);
        if (slow != '0) saddr = {1'b1, ssum[SLOT_W-1:0]};
        else            saddr = {1'b0, fsum[SLOT_W-1:0]};
        pay_wd.fast = fsum[SLOT_W-1:0];
        pay_wd.kid  = r_req.timer_kind;
        pay_wd.user = r_req.user_index;
    end

    // lowest free timer
    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = TIMERS - 1; i >= 0; i--) begin
            if (!r_tbusy[i]) begin
                free_ok  = 1'b1;
                free_idx = TID_W'(i);
            end
        end
    end

    always_comb begin
        o_stat.h_ok      = ({1'b0, r_req.handle} < (tltw_pkg::HANDLE_W + 1)'(TIMERS))
                           && r_tbusy[h_idx];
        o_stat.bad_iv    = (r_req.interval == '0) || (32'(slow) >= tltw_pkg::SLOTS);
        o_stat.full      = !free_ok;
        o_stat.wrap      = (r_fp == FP_W'(tltw_pkg::SLOTS));
        o_stat.sf_none   = tltw_pkg::is_none(r_sf_rd);
        o_stat.next_none = tltw_pkg::is_none(r_next_rd);
        o_stat.nx_none   = tltw_pkg::is_none(r_nx);
        o_stat.clr_done  = (r_clr == '1);
    end

    // memory port selection
    always_comb begin
        sf_we  = 1'b0;
        sf_wa  = r_s;
        sf_wd  = tltw_pkg::NO_TIMER;
        sf_ra  = r_s;
        nx_we  = 1'b0;
        nx_wa  = r_t[TID_W-1:0];
        nx_wd  = r_sf_rd;
        pv_we  = 1'b0;
        pv_wa  = r_t[TID_W-1:0];
        pv_wd  = tltw_pkg::NO_TIMER;
        pay_we = 1'b0;
        ts_we  = 1'b0;
        lk_ra  = h_idx;
        case (i_cmd.uop)
            tltw_pkg::UOP_CLEAR: begin
                sf_we = 1'b1;
                sf_wa = r_clr;
            end
            tltw_pkg::UOP_ALLOC: begin
                sf_ra  = saddr;
                pay_we = 1'b1;
            end
            tltw_pkg::UOP_LH_WR: begin
                // new head of slot r_s, for a fresh start and a cascade alike
                nx_we = 1'b1;
                pv_we = 1'b1;
                sf_we = 1'b1;
                sf_wd = r_t;
                ts_we = 1'b1;
            end
            tltw_pkg::UOP_LH_PREV: begin
                pv_we = !tltw_pkg::is_none(r_n);
                pv_wa = r_n[TID_W-1:0];
                pv_wd = r_t;
                lk_ra = r_nx[TID_W-1:0];
            end
            tltw_pkg::UOP_STOP_UNL: begin
                // unlink: predecessor or slot head takes the successor
                if (!tltw_pkg::is_none(r_prev_rd)) begin
                    nx_we = 1'b1;
                    nx_wa = r_prev_rd[TID_W-1:0];
                    nx_wd = r_next_rd;
                end else begin
                    sf_we = 1'b1;
                    sf_wa = r_tslot_rd;
                    sf_wd = r_next_rd;
                end
                pv_we = !tltw_pkg::is_none(r_next_rd);
                pv_wa = r_next_rd[TID_W-1:0];
                pv_wd = r_prev_rd;
            end
            tltw_pkg::UOP_CS_RD: begin
                sf_we = 1'b1;
            end
            tltw_pkg::UOP_CS_HEAD: lk_ra = r_sf_rd[TID_W-1:0];
            tltw_pkg::UOP_CS_GOT:  sf_ra = {1'b0, r_pay_rd.fast};
            tltw_pkg::UOP_EX_RD: begin
                sf_ra = {1'b0, r_fp[SLOT_W-1:0]};
                sf_wa = {1'b0, r_fp[SLOT_W-1:0]};
                sf_we = 1'b1;
            end
            tltw_pkg::UOP_EX_HEAD: lk_ra = r_sf_rd[TID_W-1:0];
            tltw_pkg::UOP_EX_OUT:  lk_ra = r_next_rd[TID_W-1:0];
            default: lk_ra = h_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (sf_we) m_sf[sf_wa] <= sf_wd;
        r_sf_rd <= m_sf[sf_ra];
    end

    always_ff @(posedge i_clk) begin
        if (nx_we) m_next[nx_wa] <= nx_wd;
        r_next_rd <= m_next[lk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pv_we) m_prev[pv_wa] <= pv_wd;
        r_prev_rd <= m_prev[h_idx];
    end

    always_ff @(posedge i_clk) begin
        if (pay_we) m_pay[free_idx] <= pay_wd;
        r_pay_rd <= m_pay[lk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ts_we) m_tslot[r_t[TID_W-1:0]] <= r_s;
        r_tslot_rd <= m_tslot[h_idx];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fp     <= '0;
            r_sp     <= '0;
            r_tick   <= '0;
            r_tbusy  <= '0;
            r_clr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            case (i_cmd.uop)
                tltw_pkg::UOP_CLEAR: r_clr <= r_clr + 1'b1;
                tltw_pkg::UOP_ALLOC: r_tbusy[free_idx] <= 1'b1;
                tltw_pkg::UOP_STOP_RD: r_tbusy[h_idx] <= 1'b0;
                tltw_pkg::UOP_TICK_CHK: begin
                    if (o_stat.wrap) begin
                        r_fp <= '0;
                        r_sp <= r_sp + 1'b1;
                    end
                end
                tltw_pkg::UOP_EX_HEAD: begin
                    if (!o_stat.sf_none) r_tbusy[r_sf_rd[TID_W-1:0]] <= 1'b0;
                end
                tltw_pkg::UOP_EX_OUT: begin
                    if (!o_stat.next_none) r_tbusy[r_next_rd[TID_W-1:0]] <= 1'b0;
                end
                default: r_clr <= r_clr;
            endcase
            if (i_cmd.finish) begin
                r_fp   <= r_fp + 1'b1;
                r_tick <= r_tick + 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.uop)
            tltw_pkg::UOP_CAPTURE: r_req <= i_req;
            tltw_pkg::UOP_ALLOC: begin
                r_t <= LINK_W'(free_idx);
                r_s <= saddr;
            end
            tltw_pkg::UOP_LH_WR:   r_n <= r_sf_rd;
            tltw_pkg::UOP_LH_PREV: r_t <= r_nx;
            tltw_pkg::UOP_STOP_RD: r_t <= LINK_W'(h_idx);
            tltw_pkg::UOP_TICK_CHK: r_s <= {1'b1, r_sp + 1'b1};
            tltw_pkg::UOP_CS_HEAD: r_t <= r_sf_rd;
            tltw_pkg::UOP_CS_GOT: begin
                r_nx <= r_next_rd;
                r_s  <= {1'b0, r_pay_rd.fast};
            end
            tltw_pkg::UOP_EX_HEAD: r_t <= r_sf_rd;
            tltw_pkg::UOP_EX_OUT:  r_t <= r_next_rd;
            default: r_t <= r_t;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_res.kind         <= i_cmd.kind;
            r_res.last         <= i_cmd.last;
            r_res.slot_handle  <= '0;
            r_res.expired_user <= '0;
            r_res.expired_kind <= '0;
            if (i_cmd.kind inside {tltw_pkg::KIND_STARTED, tltw_pkg::KIND_STOPPED,
                                   tltw_pkg::KIND_EXPIRED}) begin
                r_res.slot_handle <= r_t[tltw_pkg::HANDLE_W-1:0];
            end
            if (i_cmd.kind == tltw_pkg::KIND_BAD_HANDLE) begin
                r_res.slot_handle <= r_req.handle;
            end
            if (i_cmd.kind == tltw_pkg::KIND_EXPIRED) begin
                r_res.expired_user <= r_pay_rd.user;
                r_res.expired_kind <= r_pay_rd.kid;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

/* design/two_level_timer_wheel.sv */
// two-ring timer wheel with a pool of 64 timers. a request is taken when
// start is high and busy is low; results come back one per cycle on o_res,
// each marked by a one-cycle o_strobe, and cannot be held off, so the
// receiver must take every strobe. the final result of a request has last
// set. after reset the block sweeps the 1024-entry slot head memory, one
// entry per cycle, and busy stays high until the sweep is done. an
// accepted start allocates a timer, makes it the new head of its slot and
// links the old head back to it; an accepted stop unlinks the timer. a
// rejected start or stop returns only its error result. when the fast
// ring wraps, a tick first cascades the slow ring slot into the fast ring
// one timer at a time, then emits one result per expired timer or a
// tick-empty result. list memories have a write and a registered read port.
module two_level_timer_wheel (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  tltw_pkg::t_req    i_req,
    output logic              busy,
    output logic              o_strobe,
    output tltw_pkg::t_res    o_res
);

    // command and status between sequencer and datapath
    tltw_pkg::t_cmd  cmd;
    tltw_pkg::t_stat stat;

    // sequencer: walks the slot lists one link per step
    tltw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_req.func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // datapath: ring positions, timer pool, link memories, result register
    tltw_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule
